@@ rtl/core/rce_pkg.sv @@
package rce_pkg;

  // ASCII codes of the output characters
  localparam logic [7:0] CHR_I        = 8'h49;
  localparam logic [7:0] CHR_V        = 8'h56;
  localparam logic [7:0] CHR_X        = 8'h58;
  localparam logic [7:0] CHR_L        = 8'h4C;
  localparam logic [7:0] CHR_C        = 8'h43;
  localparam logic [7:0] CHR_D        = 8'h44;
  localparam logic [7:0] CHR_M        = 8'h4D;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Divide by ten via reciprocal: q = (x * 52429) >> 19, exact for 12-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int VALUE_W = 12;

  // Digit places, most significant first
  localparam logic [1:0] PLACE_THOUSANDS = 2'd3;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
  localparam logic [1:0] PLACE_TENS      = 2'd1;
  localparam logic [1:0] PLACE_UNITS     = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT,
    ST_NL
  } state_e;

  // Which letter of a place: one, five or ten units
  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // capture the input value
    logic split;    // one divide-by-ten step
    logic emit;     // load the current letter into the output register
    logic emit_nl;  // load the newline into the output register
    logic advance;  // move to the next letter or the next place
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic split_last;  // third divide step in progress
    logic dig_empty;   // current digit writes nothing
    logic dig_end;     // current letter is the last of its digit
    logic units;       // current place is the units
    logic out_free;    // output register can take a character
  } sts_t;

  // Number of letters a digit writes in a place
  function automatic logic [2:0] digit_len(input logic [1:0] place, input logic [3:0] d);
    logic [2:0] len;
    len = 3'd0;
    if (place == PLACE_THOUSANDS) begin
      if (d >= 4'd1 && d <= 4'd3) len = d[2:0];
    end else begin
      unique case (d)
        4'd0:    len = 3'd0;
        4'd1:    len = 3'd1;
        4'd2:    len = 3'd2;
        4'd3:    len = 3'd3;
        4'd4:    len = 3'd2;
        4'd5:    len = 3'd1;
        4'd6:    len = 3'd2;
        4'd7:    len = 3'd3;
        4'd8:    len = 3'd4;
        4'd9:    len = 3'd2;
        default: len = 3'd0;
      endcase
    end
    return len;
  endfunction

  // Letter class at a position within a digit (subtractive forms for 4 and 9)
  function automatic sym_e digit_sym(input logic [3:0] d, input logic [1:0] pos);
    sym_e s;
    s = SYM_ONE;
    if (d == 4'd9) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
    end
    return s;
  endfunction

  // ASCII letter for a class in a place
  function automatic logic [7:0] sym_char(input logic [1:0] place, input sym_e s);
    logic [7:0] c;
    c = CHR_M;
    unique case (place)
      PLACE_THOUSANDS: c = CHR_M;
      PLACE_HUNDREDS:  c = (s == SYM_ONE) ? CHR_C : ((s == SYM_FIVE) ? CHR_D : CHR_M);
      PLACE_TENS:      c = (s == SYM_ONE) ? CHR_X : ((s == SYM_FIVE) ? CHR_L : CHR_C);
      PLACE_UNITS:     c = (s == SYM_ONE) ? CHR_I : ((s == SYM_FIVE) ? CHR_V : CHR_X);
      default:         c = CHR_M;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/rce_ctrl.sv @@
module rce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rce_pkg::sts_t sts_i,
  output rce_pkg::cmd_t cmd_o
);
  import rce_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts_i.split_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // leave after the last letter of the units, or an empty units digit
        if (sts_i.units && (sts_i.dig_empty || (sts_i.dig_end && sts_i.out_free))) begin
          state_d = ST_NL;
        end
      end
      ST_NL: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.dig_empty) begin
          cmd_o.advance = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.advance = 1'b1;
        end
      end
      ST_NL: begin
        cmd_o.emit_nl = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ rtl/core/rce_dp.sv @@
module rce_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rce_pkg::VALUE_W-1:0]  value_i,
  input  rce_pkg::cmd_t                cmd_i,
  output rce_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   char_code_o,
  output logic                         last_o
);
  import rce_pkg::*;

  logic [VALUE_W-1:0] rem_q;
  logic [3:0]         digit_q [4];
  logic [1:0]         cnt_q;
  logic [1:0]         place_q;
  logic [1:0]         pos_q;
  logic               out_valid_q;
  logic [7:0]         char_q;
  logic               last_q;

  logic [27:0]        prod;
  logic [8:0]         quot;
  logic [VALUE_W-1:0] quot_ext;
  logic [VALUE_W-1:0] quot_x10;
  logic [3:0]         rem_digit;
  logic [3:0]         cur_digit;
  logic [2:0]         cur_len;
  sym_e               cur_sym;
  logic               out_free;

  // Divide by ten: reciprocal multiply, then remainder by shift-add
  assign prod      = 28'(rem_q) * 28'(DIV10_MUL);
  assign quot      = prod[27:DIV10_SHIFT];
  assign quot_ext  = VALUE_W'(quot);
  assign quot_x10  = (quot_ext << 3) + (quot_ext << 1);
  assign rem_digit = 4'(rem_q - quot_x10);

  // Current digit and letter
  assign cur_digit = digit_q[place_q];
  assign cur_len   = digit_len(place_q, cur_digit);
  assign cur_sym   = digit_sym(cur_digit, pos_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.split_last = (cnt_q == 2'd2);
  assign sts_o.dig_empty  = (cur_len == 3'd0);
  assign sts_o.dig_end    = ((3'({1'b0, pos_q}) + 3'd1) == cur_len);
  assign sts_o.units      = (place_q == PLACE_UNITS);
  assign sts_o.out_free   = out_free;

  // Digit split and letter walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      place_q <= PLACE_THOUSANDS;
      pos_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q   <= '0;
        place_q <= PLACE_THOUSANDS;
        pos_q   <= '0;
      end else begin
        if (cmd_i.split) cnt_q <= cnt_q + 2'd1;
        if (cmd_i.advance) begin
          if (sts_o.dig_empty || sts_o.dig_end) begin
            place_q <= place_q - 2'd1;
            pos_q   <= '0;
          end else begin
            pos_q <= pos_q + 2'd1;
          end
        end
      end
    end
  end

  // Value and digit registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
    end else if (cmd_i.split) begin
      rem_q          <= quot_ext;
      digit_q[cnt_q] <= rem_digit;
      if (cnt_q == 2'd2) digit_q[PLACE_THOUSANDS] <= quot[3:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_nl) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= sym_char(place_q, cur_sym);
      last_q <= 1'b0;
    end else if (cmd_i.emit_nl) begin
      char_q <= NEWLINE_CODE;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

@@ rtl/core/roman_numeral_encoder.sv @@
// After the input transfer the value is split into digits, then one character per cycle while out_stall_i is low.
// A zero digit is passed over in a step of its own; the newline follows the last letter.
// 3888 gives the longest output: 15 letters and the newline.
// The next input is taken once the newline sits in the output register.
// Reset (rst_ni, async, active low) empties the output register and returns to idle.
module roman_numeral_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rce_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  char_code_o,
  output logic                        last_o
);
  import rce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/core/rce_chk.sv @@
module rce_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [rce_pkg::VALUE_W-1:0] value_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [7:0]                  char_code_o,
  input logic                        last_o
);
  import rce_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o) && $stable(last_o))
    else $error("stalled result changed");

  // Last transfer is always the newline
  a_last_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> char_code_o == NEWLINE_CODE)
    else $error("last without newline");

  // Other transfers are Roman letters
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (char_code_o == CHR_I || char_code_o == CHR_V ||
      char_code_o == CHR_X || char_code_o == CHR_L || char_code_o == CHR_C ||
      char_code_o == CHR_D || char_code_o == CHR_M))
    else $error("bad letter");

  // One item at a time: input stalls right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second input taken during conversion");

endmodule

bind roman_numeral_encoder rce_chk u_rce_chk (.*);
